>>> hw/rtl/ybpc_pkg.sv
// ----------------------------------------------------------------------------
// ybpc_pkg
// Shared widths, constants, coefficient sets and helpers for the YUV to BGR
// pixel converter.
// ----------------------------------------------------------------------------
package ybpc_pkg;

   localparam int PIX_W  = 8;
   localparam int FRAC_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_STANDARD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITED_RANGE   = 2'd1;

   localparam logic [1:0] MATRIX_BT601  = 2'd0;
   localparam logic [1:0] MATRIX_BT709  = 2'd1;
   localparam logic [1:0] MATRIX_BT2020 = 2'd2;

   localparam logic signed [20:0] Y_GAIN     = 21'sd1192;
   localparam logic signed [20:0] Y_OFFSET   = 21'sd19072;
   localparam logic signed [20:0] C_GAIN     = 21'sd1166;
   localparam logic signed [8:0]  C_BIAS     = 9'sd128;

   typedef struct packed {
      logic signed [11:0] kr;
      logic signed [11:0] kgu;
      logic signed [11:0] kgv;
      logic signed [11:0] kb;
   } coef_type;

   function automatic coef_type coef_lookup(input logic [1:0] matrix);
      coef_type c;
      case (matrix)
         MATRIX_BT709: begin
            c.kr = 12'sd1613; c.kgu = 12'sd192; c.kgv = 12'sd479; c.kb = 12'sd1900;
         end
         MATRIX_BT2020: begin
            c.kr = 12'sd1510; c.kgu = 12'sd168; c.kgv = 12'sd585; c.kb = 12'sd1926;
         end
         default: begin
            c.kr = 12'sd1436; c.kgu = 12'sd352; c.kgv = 12'sd731; c.kb = 12'sd1815;
         end
      endcase
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] sat8(input logic signed [12:0] v);
      logic [PIX_W-1:0] r;
      if (v < 13'sd0) begin
         r = '0;
      end else if (v > 13'sd255) begin
         r = '1;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ybpc_yuv_if.sv
// ----------------------------------------------------------------------------
// ybpc_yuv_if
// Valid/ready channel carrying one YUV pixel.
// ----------------------------------------------------------------------------
interface ybpc_yuv_if;
   logic                       valid;
   logic                       ready;
   logic [ybpc_pkg::PIX_W-1:0] luma;
   logic [ybpc_pkg::PIX_W-1:0] chroma_blue;
   logic [ybpc_pkg::PIX_W-1:0] chroma_red;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   input ready);
   modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                 output ready);
endinterface

>>> hw/rtl/ybpc_bgr_if.sv
// ----------------------------------------------------------------------------
// ybpc_bgr_if
// Valid/ready channel carrying one BGR pixel.
// ----------------------------------------------------------------------------
interface ybpc_bgr_if;
   logic                       valid;
   logic                       ready;
   logic [ybpc_pkg::PIX_W-1:0] blue;
   logic [ybpc_pkg::PIX_W-1:0] green;
   logic [ybpc_pkg::PIX_W-1:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink (input valid, input blue, input green, input red, output ready);
endinterface

>>> hw/rtl/yuv_to_bgra_pixel_convert_core.sv
// A req transfer passes through three register stages (range expansion,
// coefficient multiply, sum and saturate); rsp valid is the last stage's
// valid bit. Each stage holds while the next is full; one pixel per cycle
// while rsp.ready is high.
// Reset: synchronous, clears stage valid bits, matrix_standard and limited_range;
// req ready stays low while reset is high.
// ----------------------------------------------------------------------------
// yuv_to_bgra_pixel_convert_core
// Fixed-point YUV to BGR conversion, BT.601/709/2020, full or limited range.
// ----------------------------------------------------------------------------
module yuv_to_bgra_pixel_convert_core (
   input  logic                            clock,
   input  logic                            reset,
   ybpc_yuv_if.sink                        req,
   ybpc_bgr_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [ybpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ybpc_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   logic [1:0] matrix_ff;
   logic       limited_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff  <= ybpc_pkg::MATRIX_BT601;
         limited_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ybpc_pkg::CSR_MATRIX_STANDARD: matrix_ff  <= csr_wr_data[1:0];
            ybpc_pkg::CSR_LIMITED_RANGE:   limited_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic adv1, adv2, adv3;

   assign adv3      = !s3_valid_ff || rsp.ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req.ready = adv1 && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: chroma bias removal, range expansion when limited range is set
   logic signed [20:0] luma_s, y_prod, u_prod, v_prod;
   logic signed [8:0]  cb_s, cr_s;
   logic signed [9:0]  y_in;
   logic signed [8:0]  u_in, v_in;
   logic signed [9:0]  y1_ff;
   logic signed [8:0]  u1_ff, v1_ff;

   always_comb begin
      luma_s = $signed({13'd0, req.luma});
      cb_s   = $signed({1'b0, req.chroma_blue}) - ybpc_pkg::C_BIAS;
      cr_s   = $signed({1'b0, req.chroma_red}) - ybpc_pkg::C_BIAS;
      y_prod = luma_s * ybpc_pkg::Y_GAIN - ybpc_pkg::Y_OFFSET;
      u_prod = 21'(cb_s) * ybpc_pkg::C_GAIN;
      v_prod = 21'(cr_s) * ybpc_pkg::C_GAIN;
      if (limited_ff) begin
         y_in = $signed(y_prod[19:10]);
         u_in = $signed(u_prod[18:10]);
         v_in = $signed(v_prod[18:10]);
      end else begin
         y_in = $signed({2'b00, req.luma});
         u_in = cb_s;
         v_in = cr_s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req.valid) begin
         y1_ff <= y_in;
         u1_ff <= u_in;
         v1_ff <= v_in;
      end
   end

   // stage 2: coefficient multiply
   ybpc_pkg::coef_type coef;
   logic signed [20:0] p_r_in, p_gu_in, p_gv_in, p_b_in;
   logic signed [20:0] p_r_ff, p_gu_ff, p_gv_ff, p_b_ff;
   logic signed [9:0]  y2_ff;

   always_comb begin
      coef    = ybpc_pkg::coef_lookup(matrix_ff);
      p_r_in  = 21'(v1_ff) * 21'(coef.kr);
      p_gu_in = 21'(u1_ff) * 21'(coef.kgu);
      p_gv_in = 21'(v1_ff) * 21'(coef.kgv);
      p_b_in  = 21'(u1_ff) * 21'(coef.kb);
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         y2_ff   <= y1_ff;
         p_r_ff  <= p_r_in;
         p_gu_ff <= p_gu_in;
         p_gv_ff <= p_gv_in;
         p_b_ff  <= p_b_in;
      end
   end

   // stage 3: sum, floor shift, saturate
   logic signed [21:0] g_sum;
   logic signed [12:0] r_val, g_val, b_val;
   logic [ybpc_pkg::PIX_W-1:0] blue_ff, green_ff, red_ff;

   always_comb begin
      g_sum = 22'(p_gu_ff) + 22'(p_gv_ff);
      r_val = 13'(y2_ff) + 13'($signed(p_r_ff[20:10]));
      g_val = 13'(y2_ff) - 13'($signed(g_sum[21:10]));
      b_val = 13'(y2_ff) + 13'($signed(p_b_ff[20:10]));
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         blue_ff  <= ybpc_pkg::sat8(b_val);
         green_ff <= ybpc_pkg::sat8(g_val);
         red_ff   <= ybpc_pkg::sat8(r_val);
      end
   end

   assign rsp.valid = s3_valid_ff;
   assign rsp.blue  = blue_ff;
   assign rsp.green = green_ff;
   assign rsp.red   = red_ff;

endmodule
